@@ hdl/assert_macros.svh @@
// Assertion helpers; define NO_ASSERTIONS to compile them away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ hdl/cse_pkg.sv @@
package cse_pkg;

    localparam int MODE_W   = 2;
    localparam int SID_W    = 3;
    localparam int CNT_W    = 16;
    localparam int PID_W    = 16;
    localparam int STATUS_W = 2;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 24;

    typedef enum logic [MODE_W-1:0] {
        OP_CREATE  = 2'd0,
        OP_WAIT    = 2'd1,
        OP_POST    = 2'd2,
        OP_DESTROY = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_BLOCKED = 2'd1,
        ST_ERR     = 2'd2
    } status_t;

    // controller -> datapath
    typedef struct packed {
        logic    load_in;
        logic    create;
        logic    dec;
        logic    enqueue;
        logic    inc;
        logic    dequeue;
        logic    clear;
        logic    drain_step;
        logic    emit;
        status_t emit_status;
        logic    emit_wake;
        logic    emit_last;
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        op_t  op;
        logic bad_id;
        logic full;
        logic count_pos;
        logic q_empty;
        logic q_full;
        logic rem_last;
        logic out_free;
    } dp_status_t;

endpackage

@@ hdl/counting_semaphore_engine_core.sv @@
// Counting semaphore engine: a table of NUM_SEMS semaphores, each with a
// count and a FIFO of up to WAIT_DEPTH waiting process ids.
// Input channel (s_): one transfer per operation (create, wait, post,
// destroy). Result channel (m_): one or more transfers per operation,
// the final one flagged by m_tlast; m_tuser marks a result that wakes a
// process named in the woken_pid field.
// Sequence from acceptance: create, wait, error cases, and post or destroy
// on an empty queue give their one result straight from the execute state.
// A post that wakes a waiter adds one queue memory read and one result; a
// destroy with n waiters does a read of the queue memory followed by a
// result for each woken id in turn.
// One operation is in flight at a time; the result register lets the
// next operation be accepted while the last result is still waiting.
// A stalled receiver (m_tready low) holds the result register; the engine
// waits before writing another result and loses nothing.
// Reset (aresetn low, synchronous) frees every slot at once; queue memory
// needs no clearing since only entries within a slot's waiter total are read.
module counting_semaphore_engine_core
    import cse_pkg::*;
#(
    parameter int NUM_SEMS   = 8,
    parameter int WAIT_DEPTH = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [1:0] mode, [4:2] sem_id, [20:5] initial_count, [36:21] caller_pid
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [1:0] status, [4:2] slot_id, [20:5] woken_pid
    output logic [M_TDATA_W-1:0] m_tdata,
    // [0] wake_valid
    output logic                 m_tuser,
    output logic                 m_tlast
);

`include "assert_macros.svh"

    ctrl_cmd_t  cmd;
    dp_status_t st;

    cse_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    cse_dp #(
        .NUM_SEMS   (NUM_SEMS),
        .WAIT_DEPTH (WAIT_DEPTH)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .st       (st),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // only destroy gives more than one result, and each of those wakes someone
    `ASSERT_IMPLIES(a_nonlast_wakes, aclk, aresetn, m_tvalid && !m_tlast, m_tuser)
    `ASSERT_IMPLIES(a_err_single, aclk, aresetn, m_tvalid && (m_tdata[1:0] == ST_ERR), m_tlast && !m_tuser)
    `ASSERT_IMPLIES(a_blocked_nowake, aclk, aresetn, m_tvalid && (m_tdata[1:0] == ST_BLOCKED), !m_tuser && m_tlast)
    `ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_tvalid && s_tready, !s_tready)

endmodule

@@ hdl/cse_ram.sv @@
module cse_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/cse_ctrl.sv @@
module cse_ctrl
    import cse_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t st,
    output ctrl_cmd_t  cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RD,
        S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg;

    always_comb begin
        cmd         = '0;
        cmd.emit_status = ST_OK;
        state_next  = state_reg;
        case (state_reg)
            S_IDLE: begin
                cmd.load_in = s_tvalid & ready_reg;
                if (s_tvalid && ready_reg) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.emit_last = 1'b1;
                if (st.op == OP_CREATE) begin
                    if (st.out_free) begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = st.full ? ST_ERR : ST_OK;
                        cmd.create      = !st.full;
                        state_next      = S_IDLE;
                    end
                end else if (st.bad_id) begin
                    if (st.out_free) begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = ST_ERR;
                        state_next      = S_IDLE;
                    end
                end else if (st.op == OP_WAIT) begin
                    if (st.out_free) begin
                        cmd.emit = 1'b1;
                        if (st.count_pos) begin
                            cmd.dec = 1'b1;
                        end else if (st.q_full) begin
                            cmd.emit_status = ST_ERR;
                        end else begin
                            cmd.enqueue     = 1'b1;
                            cmd.emit_status = ST_BLOCKED;
                        end
                        state_next = S_IDLE;
                    end
                end else if (st.q_empty) begin
                    // post or destroy with nobody waiting: one plain result
                    if (st.out_free) begin
                        cmd.emit   = 1'b1;
                        cmd.inc    = (st.op == OP_POST);
                        cmd.clear  = (st.op == OP_DESTROY);
                        state_next = S_IDLE;
                    end
                end else begin
                    // tables settle now; the queue memory is drained after
                    cmd.inc     = (st.op == OP_POST);
                    cmd.dequeue = (st.op == OP_POST);
                    cmd.clear   = (st.op == OP_DESTROY);
                    state_next  = S_RD;
                end
            end
            S_RD: begin
                state_next = S_OUT;
            end
            S_OUT: begin
                if (st.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_wake = 1'b1;
                    cmd.emit_last = st.rem_last;
                    if (st.rem_last) begin
                        state_next = S_IDLE;
                    end else begin
                        cmd.drain_step = 1'b1;
                        state_next     = S_RD;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ready_reg <= 1'b1;
        end else begin
            state_reg <= state_next;
            ready_reg <= (state_next == S_IDLE);
        end
    end

    assign s_tready = ready_reg;

endmodule

@@ hdl/cse_dp.sv @@
module cse_dp
    import cse_pkg::*;
#(
    parameter int NUM_SEMS   = 8,
    parameter int WAIT_DEPTH = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ctrl_cmd_t            cmd,
    output dp_status_t           st,
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tuser,
    output logic                 m_tlast
);

    localparam int SW        = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
    localparam int PW        = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam int TW        = $clog2(WAIT_DEPTH + 1);
    localparam int RAM_DEPTH = NUM_SEMS * (2 ** PW);

    // latched request
    op_t                     op_reg;
    logic [SID_W-1:0]        sid_reg;
    logic signed [CNT_W-1:0] init_reg;
    logic [PID_W-1:0]        pid_reg;

    // semaphore table; queues are circular buffers in the memory
    logic [NUM_SEMS-1:0] in_use_reg;
    logic [CNT_W-1:0]    count_reg [NUM_SEMS];
    logic [PW-1:0]       head_reg  [NUM_SEMS];
    logic [TW-1:0]       total_reg [NUM_SEMS];

    // drain cursor
    logic [PW-1:0] ptr_reg;
    logic [TW-1:0] rem_reg;

    // result register
    logic                m_valid_reg;
    status_t             m_status_reg;
    logic [SID_W-1:0]    m_slot_reg;
    logic                m_wake_reg;
    logic [PID_W-1:0]    m_pid_reg;
    logic                m_last_reg;

    logic [SW-1:0]    sid_idx;
    logic [SW-1:0]    free_idx;
    logic             full;
    logic [CNT_W-1:0] count_cur;
    logic [PW-1:0]    head_cur;
    logic [TW-1:0]    total_cur;
    logic [PW-1:0]    head_inc;
    logic [PW-1:0]    ptr_inc;
    logic [PW:0]      tail_sum;
    logic [PW-1:0]    tail;
    logic [PID_W-1:0] ram_rdata;
    logic             out_free;
    logic [SID_W-1:0] slot_sel;

    assign sid_idx   = SW'(sid_reg);
    assign count_cur = count_reg[sid_idx];
    assign head_cur  = head_reg[sid_idx];
    assign total_cur = total_reg[sid_idx];

    always_comb begin
        free_idx = '0;
        full     = 1'b1;
        for (int i = NUM_SEMS - 1; i >= 0; i--) begin
            if (!in_use_reg[i]) begin
                free_idx = SW'(i);
                full     = 1'b0;
            end
        end
    end

    assign head_inc = (head_cur == PW'(WAIT_DEPTH - 1)) ? '0 : head_cur + 1'b1;
    assign ptr_inc  = (ptr_reg == PW'(WAIT_DEPTH - 1)) ? '0 : ptr_reg + 1'b1;
    assign tail_sum = {1'b0, head_cur} + (PW+1)'(total_cur);
    assign tail     = (tail_sum >= (PW+1)'(WAIT_DEPTH))
                    ? PW'(tail_sum - (PW+1)'(WAIT_DEPTH)) : PW'(tail_sum);

    assign out_free = !m_valid_reg || m_tready;

    assign st.op        = op_reg;
    assign st.bad_id    = (int'(sid_reg) >= NUM_SEMS) || !in_use_reg[sid_idx];
    assign st.full      = full;
    assign st.count_pos = (count_cur != '0);
    assign st.q_empty   = (total_cur == '0);
    assign st.q_full    = (total_cur == TW'(WAIT_DEPTH));
    assign st.rem_last  = (rem_reg == TW'(1));
    assign st.out_free  = out_free;

    always_comb begin
        if (op_reg != OP_CREATE) begin
            slot_sel = sid_reg;
        end else if (full) begin
            slot_sel = '0;
        end else begin
            slot_sel = SID_W'(free_idx);
        end
    end

    cse_ram #(
        .WIDTH (PID_W),
        .DEPTH (RAM_DEPTH)
    ) u_queue_ram (
        .aclk  (aclk),
        .we    (cmd.enqueue),
        .waddr ({sid_idx, tail}),
        .wdata (pid_reg),
        .raddr ({sid_idx, ptr_reg}),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            op_reg   <= op_t'(s_tdata[1:0]);
            sid_reg  <= s_tdata[4:2];
            init_reg <= s_tdata[20:5];
            pid_reg  <= s_tdata[36:21];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_use_reg <= '0;
            for (int i = 0; i < NUM_SEMS; i++) begin
                count_reg[i] <= '0;
                head_reg[i]  <= '0;
                total_reg[i] <= '0;
            end
            ptr_reg <= '0;
            rem_reg <= '0;
        end else begin
            if (cmd.create) begin
                in_use_reg[free_idx] <= 1'b1;
                count_reg[free_idx]  <= init_reg[CNT_W-1] ? '0 : $unsigned(init_reg);
                total_reg[free_idx]  <= '0;
            end
            if (cmd.dec) begin
                count_reg[sid_idx] <= count_cur - 1'b1;
            end
            if (cmd.enqueue) begin
                total_reg[sid_idx] <= total_cur + 1'b1;
            end
            if (cmd.inc && (count_cur != '1)) begin
                count_reg[sid_idx] <= count_cur + 1'b1;
            end
            if (cmd.dequeue) begin
                head_reg[sid_idx]  <= head_inc;
                total_reg[sid_idx] <= total_cur - 1'b1;
                ptr_reg            <= head_cur;
                rem_reg            <= TW'(1);
            end
            if (cmd.clear) begin
                in_use_reg[sid_idx] <= 1'b0;
                count_reg[sid_idx]  <= '0;
                total_reg[sid_idx]  <= '0;
                ptr_reg             <= head_cur;
                rem_reg             <= total_cur;
            end
            if (cmd.drain_step) begin
                ptr_reg <= ptr_inc;
                rem_reg <= rem_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_status_reg <= cmd.emit_status;
            m_slot_reg   <= slot_sel;
            m_wake_reg   <= cmd.emit_wake;
            m_pid_reg    <= cmd.emit_wake ? ram_rdata : '0;
            m_last_reg   <= cmd.emit_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, m_pid_reg, m_slot_reg, m_status_reg};
    assign m_tuser  = m_wake_reg;
    assign m_tlast  = m_last_reg;

endmodule

@@ bench/testbench.sv @@
module testbench;
    import cse_pkg::*;

    localparam int NUM_SEMS       = 8;
    localparam int WAIT_DEPTH     = 16;
    localparam int RANDOM_ITEMS   = 160;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 16;
    localparam int SCRIPT_ROWS    = 18;

    typedef struct packed {
        status_t    status;
        logic [2:0] slot;
        logic       wake;
        logic [15:0] pid;
        logic       last;
    } sem_result_t;

    typedef struct {
        op_t         op;
        logic [2:0]  sid;
        logic [15:0] init;
        logic [15:0] pid;
        int          rep;
        bit          typed;
        sem_result_t res;
    } script_row_t;

    localparam sem_result_t NO_RES = '{ST_OK, 3'd0, 1'b0, 16'h0, 1'b0};

    logic                 aclk;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // [1:0] mode, [4:2] sem_id, [20:5] initial_count, [36:21] caller_pid
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // [1:0] status, [4:2] slot_id, [20:5] woken_pid
    logic [M_TDATA_W-1:0] m_tdata;
    // [0] wake_valid
    logic                 m_tuser;
    logic                 m_tlast;

    // shadow copy of the semaphore table
    logic        sem_used  [NUM_SEMS];
    logic [15:0] sem_cnt   [NUM_SEMS];
    logic [4:0]  sem_nwait [NUM_SEMS];
    logic [15:0] sem_queue [NUM_SEMS][WAIT_DEPTH];

    sem_result_t pending_results[$];
    int          mismatches  = 0;
    int          idle_cycles = 0;
    int          burst_left  = 0;

    counting_semaphore_engine_core #(
        .NUM_SEMS  (NUM_SEMS),
        .WAIT_DEPTH(WAIT_DEPTH)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic logic [S_TDATA_W-1:0] pack_op(op_t op, logic [2:0] sid,
                                                      logic [15:0] init, logic [15:0] pid);
        return {3'b000, pid, init, sid, op};
    endfunction

    // Applies one operation to the shadow table and queues its results.
    task automatic semaphore_predict(input logic [S_TDATA_W-1:0] word);
        op_t         op;
        logic [2:0]  sid;
        logic [15:0] init;
        logic [15:0] pid;
        logic [15:0] woken;
        int          slot;
        int          n;
        op   = op_t'(word[1:0]);
        sid  = word[4:2];
        init = word[20:5];
        pid  = word[36:21];
        if (op == OP_CREATE) begin
            slot = -1;
            for (int i = NUM_SEMS - 1; i >= 0; i--)
                if (!sem_used[i]) slot = i;
            if (slot < 0) begin
                pending_results.push_back('{ST_ERR, 3'd0, 1'b0, 16'h0, 1'b1});
            end else begin
                sem_used[slot]  = 1'b1;
                sem_cnt[slot]   = init[15] ? 16'h0 : init;
                sem_nwait[slot] = '0;
                pending_results.push_back('{ST_OK, 3'(slot), 1'b0, 16'h0, 1'b1});
            end
        end else if (!sem_used[sid]) begin
            pending_results.push_back('{ST_ERR, sid, 1'b0, 16'h0, 1'b1});
        end else begin
            n = sem_nwait[sid];
            case (op)
                OP_WAIT: begin
                    if (sem_cnt[sid] != 0) begin
                        sem_cnt[sid]--;
                        pending_results.push_back('{ST_OK, sid, 1'b0, 16'h0, 1'b1});
                    end else if (n >= WAIT_DEPTH) begin
                        pending_results.push_back('{ST_ERR, sid, 1'b0, 16'h0, 1'b1});
                    end else begin
                        sem_queue[sid][n] = pid;
                        sem_nwait[sid]    = 5'(n + 1);
                        pending_results.push_back('{ST_BLOCKED, sid, 1'b0, 16'h0, 1'b1});
                    end
                end
                OP_POST: begin
                    if (sem_cnt[sid] != 16'hFFFF) sem_cnt[sid]++;
                    if (n > 0) begin
                        woken = sem_queue[sid][0];
                        for (int i = 1; i < n; i++)
                            sem_queue[sid][i-1] = sem_queue[sid][i];
                        sem_nwait[sid] = 5'(n - 1);
                        pending_results.push_back('{ST_OK, sid, 1'b1, woken, 1'b1});
                    end else begin
                        pending_results.push_back('{ST_OK, sid, 1'b0, 16'h0, 1'b1});
                    end
                end
                default: begin
                    sem_used[sid]  = 1'b0;
                    sem_cnt[sid]   = '0;
                    sem_nwait[sid] = '0;
                    if (n == 0)
                        pending_results.push_back('{ST_OK, sid, 1'b0, 16'h0, 1'b1});
                    for (int i = 0; i < n; i++)
                        pending_results.push_back('{ST_OK, sid, 1'b1, sem_queue[sid][i],
                                                    1'(i == n - 1)});
                end
            endcase
        end
    endtask

    // Sends one operation; prediction happens at the accepting edge.
    task automatic send_op(input logic [S_TDATA_W-1:0] word, input bit typed,
                           input sem_result_t typed_res);
        int n0;
        int gap;
        if (burst_left == 0) begin
            gap        = $urandom_range(0, 6);
            burst_left = $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_tdata  <= word;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        n0 = pending_results.size();
        semaphore_predict(word);
        if (typed) begin
            while (pending_results.size() > n0) void'(pending_results.pop_back());
            pending_results.push_back(typed_res);
        end
        @(negedge aclk);
    endtask

    // receiver stall pattern, redrawn at random from four modes
    int rx_phase = 0;
    int rx_mode  = 0;
    always @(negedge aclk) begin
        rx_phase <= rx_phase + 1;
        if (rx_phase % 64 == 63) rx_mode <= $urandom_range(0, 3);
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            2: m_tready <= ((rx_phase % 7) >= 3);
            default: m_tready <= (rx_phase % 32) > 20;
        endcase
    end

    always @(posedge aclk) begin
        sem_result_t want;
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    $error("unexpected result transfer: tdata %h", m_tdata);
                    mismatches++;
                end else begin
                    want = pending_results.pop_front();
                    if (m_tdata[1:0] != want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_tdata[1:0]);
                        mismatches++;
                    end
                    if (m_tdata[4:2] != want.slot) begin
                        $error("slot_id: expected %0d, got %0d", want.slot, m_tdata[4:2]);
                        mismatches++;
                    end
                    if (m_tuser != want.wake) begin
                        $error("wake_valid: expected %0d, got %0d", want.wake, m_tuser);
                        mismatches++;
                    end
                    if (m_tdata[20:5] != want.pid) begin
                        $error("woken_pid: expected %h, got %h", want.pid, m_tdata[20:5]);
                        mismatches++;
                    end
                    if (m_tlast != want.last) begin
                        $error("last: expected %0d, got %0d", want.last, m_tlast);
                        mismatches++;
                    end
                end
            end
        end
    end

    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge aclk);
        $display("testbench failed");
        $finish;
    end

    initial begin
        script_row_t          script [SCRIPT_ROWS];
        logic [S_TDATA_W-1:0] word;
        logic [63:0]          rnd;
        op_t                  op;
        logic [2:0]           sid;
        logic [15:0]          init;
        int                   r_op;
        int                   roll;
        int                   flood_left;
        logic [2:0]           flood_sid;

        for (int i = 0; i < NUM_SEMS; i++) begin
            sem_used[i]  = 1'b0;
            sem_cnt[i]   = '0;
            sem_nwait[i] = '0;
        end

        // unused ids right after reset
        script[0]  = '{OP_WAIT,    3'd0, 16'h0000, 16'h0000, 1, 1'b1,
                       '{ST_ERR, 3'd0, 1'b0, 16'h0, 1'b1}};
        script[1]  = '{OP_POST,    3'd7, 16'h0000, 16'h0000, 1, 1'b1,
                       '{ST_ERR, 3'd7, 1'b0, 16'h0, 1'b1}};
        script[2]  = '{OP_DESTROY, 3'd5, 16'h0000, 16'h0000, 1, 1'b1,
                       '{ST_ERR, 3'd5, 1'b0, 16'h0, 1'b1}};
        // most negative count clamps to zero; sem_id ignored by create
        script[3]  = '{OP_CREATE,  3'd7, 16'h8000, 16'h0000, 1, 1'b1,
                       '{ST_OK, 3'd0, 1'b0, 16'h0, 1'b1}};
        script[4]  = '{OP_CREATE,  3'd0, 16'h7FFF, 16'h0000, 1, 1'b1,
                       '{ST_OK, 3'd1, 1'b0, 16'h0, 1'b1}};
        script[5]  = '{OP_CREATE,  3'd0, 16'hFFFF, 16'h0000, 1, 1'b1,
                       '{ST_OK, 3'd2, 1'b0, 16'h0, 1'b1}};
        script[6]  = '{OP_WAIT,    3'd0, 16'h0000, 16'hFFFF, 1, 1'b1,
                       '{ST_BLOCKED, 3'd0, 1'b0, 16'h0, 1'b1}};
        script[7]  = '{OP_WAIT,    3'd1, 16'h0000, 16'h0000, 1, 1'b1,
                       '{ST_OK, 3'd1, 1'b0, 16'h0, 1'b1}};
        script[8]  = '{OP_POST,    3'd2, 16'h0000, 16'h0000, 1, 1'b1,
                       '{ST_OK, 3'd2, 1'b0, 16'h0, 1'b1}};
        script[9]  = '{OP_POST,    3'd0, 16'h0000, 16'h0000, 1, 1'b1,
                       '{ST_OK, 3'd0, 1'b1, 16'hFFFF, 1'b1}};
        script[10] = '{OP_WAIT,    3'd0, 16'h0000, 16'h1111, 1, 1'b0, NO_RES};
        // fill the wait queue, then one more wait overflows it
        script[11] = '{OP_WAIT,    3'd0, 16'h0000, 16'hA000, WAIT_DEPTH, 1'b0, NO_RES};
        script[12] = '{OP_WAIT,    3'd0, 16'h0000, 16'h5555, 1, 1'b1,
                       '{ST_ERR, 3'd0, 1'b0, 16'h0, 1'b1}};
        script[13] = '{OP_DESTROY, 3'd0, 16'h0000, 16'h0000, 1, 1'b0, NO_RES};
        script[14] = '{OP_DESTROY, 3'd2, 16'h0000, 16'h0000, 1, 1'b1,
                       '{ST_OK, 3'd2, 1'b0, 16'h0, 1'b1}};
        script[15] = '{OP_CREATE,  3'd0, 16'h0005, 16'h0000, NUM_SEMS - 1, 1'b0, NO_RES};
        script[16] = '{OP_CREATE,  3'd0, 16'h0000, 16'h0000, 1, 1'b1,
                       '{ST_ERR, 3'd0, 1'b0, 16'h0, 1'b1}};
        script[17] = '{OP_DESTROY, 3'd7, 16'h0000, 16'h0000, 1, 1'b1,
                       '{ST_OK, 3'd7, 1'b0, 16'h0, 1'b1}};

        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (script[r])
            for (int k = 0; k < script[r].rep; k++)
                send_op(pack_op(script[r].op, script[r].sid, script[r].init,
                                16'(script[r].pid + k)),
                        script[r].typed, script[r].res);

        flood_left = 0;
        flood_sid  = '0;
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            roll = $urandom_range(0, 99);
            rnd  = {$urandom, $urandom};
            sid  = 3'($urandom_range(0, NUM_SEMS - 1));
            if ($urandom_range(0, 9) != 0)
                repeat (8) if (!sem_used[sid]) sid = 3'($urandom_range(0, NUM_SEMS - 1));
            init = ($urandom_range(0, 3) == 0) ? rnd[15:0] : 16'($urandom_range(0, 2));
            if (flood_left > 0) begin
                flood_left--;
                word = pack_op(OP_WAIT, flood_sid, init, rnd[31:16]);
            end else if (roll < 8) begin
                word = {3'b000, rnd[36:0]};
            end else if (roll < 13) begin
                // burst of waits on one slot, more than its queue can hold
                flood_sid  = sid;
                flood_left = WAIT_DEPTH + $urandom_range(0, 3);
                word = pack_op(OP_WAIT, flood_sid, init, rnd[31:16]);
            end else begin
                r_op = $urandom_range(0, 99);
                if (r_op < 20)      op = OP_CREATE;
                else if (r_op < 55) op = OP_WAIT;
                else if (r_op < 85) op = OP_POST;
                else                op = OP_DESTROY;
                word = pack_op(op, sid, init, rnd[31:16]);
            end
            send_op(word, 1'b0, NO_RES);
        end
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
